@@ hdl/bsf_pkg.sv @@
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants of the byte-stuffing framer.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int LEN_BITS_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_IDX_BITS    = 3;
  localparam int CFG_DATA_BITS   = 16;
  localparam int MAX_RESULTS     = 4;
  localparam int SLOT_BITS       = 2;
  localparam int FLEN_BITS       = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DECODE_MODE     = 3'd0,
    REG_FLAG_BYTE       = 3'd1,
    REG_ESCAPE_BYTE     = 3'd2,
    REG_FLAG_SUB_BYTE   = 3'd3,
    REG_ESCAPE_SUB_BYTE = 3'd4,
    REG_MAX_LEN         = 3'd5
  } bsf_reg_t;

  // all results caused by one input item
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] data;
    logic [MAX_RESULTS-1:0]      valid;
    logic [SLOT_BITS-1:0]        last_idx;
    logic                        done;
    logic                        err;
    logic [FLEN_BITS-1:0]        length;
  } bsf_cmd_t;

  typedef struct packed {
    logic     valid;
    bsf_cmd_t cmd;
  } bsf_push_t;

  typedef struct packed {
    logic     valid;
    bsf_cmd_t cmd;
  } bsf_head_t;

endpackage

@@ hdl/bsf_front.sv @@
// ----------------------------------------------------------------------------
// bsf_front
// Holds configuration and frame state, classifies each input byte and
// produces one command with all results that the byte causes.
// ----------------------------------------------------------------------------
module bsf_front #(
  parameter int LEN_BITS = bsf_pkg::LEN_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bsf_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bsf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  input  logic                             in_last,
  input  logic                             q_full,
  output bsf_pkg::bsf_push_t               push
);
  import bsf_pkg::*;

  localparam int CW = ((LEN_BITS > FLEN_BITS) ? LEN_BITS : FLEN_BITS) + 3;
  localparam logic [CW-1:0] CNT_MAX = {{(CW-LEN_BITS){1'b0}}, {LEN_BITS{1'b1}}};
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  function automatic logic [CW-1:0] sat(input logic [CW-1:0] v);
    return (v > CNT_MAX) ? CNT_MAX : v;
  endfunction

  logic                decode_mode;
  logic [7:0]          flag_byte;
  logic [7:0]          escape_byte;
  logic [7:0]          flag_sub_byte;
  logic [7:0]          escape_sub_byte;
  logic [15:0]         max_len;

  logic                in_frame, in_frame_next;
  logic                after_escape, after_escape_next;
  logic                discarding, discarding_next;
  logic [LEN_BITS-1:0] out_count, out_count_next;
  logic [LEN_BITS-1:0] in_count, in_count_next;

  logic                accept;
  logic                err;
  logic [2:0]          n;
  logic [CW-1:0]       oc, ic, ml;
  bsf_cmd_t            cmd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd               = '0;
    n                 = 3'd0;
    err               = 1'b0;
    oc                = CW'(out_count);
    ic                = CW'(in_count);
    ml                = CW'(max_len);
    in_frame_next     = in_frame;
    after_escape_next = after_escape;
    discarding_next   = discarding;
    if (discarding) begin
      // swallow the rest of a failed frame
    end else if (!decode_mode) begin
      if (!in_frame) begin
        cmd.data[n[1:0]] = flag_byte; cmd.valid[n[1:0]] = 1'b1; n = n + 3'd1;
        oc = sat(oc + ONE);
        in_frame_next = 1'b1;
      end
      if (in_byte == flag_byte || in_byte == escape_byte) begin
        if (oc + TWO > ml) begin
          err = 1'b1;
        end else begin
          cmd.data[n[1:0]] = escape_byte; cmd.valid[n[1:0]] = 1'b1; n = n + 3'd1;
          cmd.data[n[1:0]] = (in_byte == flag_byte) ? flag_sub_byte : escape_sub_byte;
          cmd.valid[n[1:0]] = 1'b1; n = n + 3'd1;
          oc = sat(oc + TWO);
        end
      end else if (oc + ONE > ml) begin
        err = 1'b1;
      end else begin
        cmd.data[n[1:0]] = in_byte; cmd.valid[n[1:0]] = 1'b1; n = n + 3'd1;
        oc = sat(oc + ONE);
      end
      if (!err && in_last) begin
        if (oc + ONE > ml) begin
          err = 1'b1;
        end else begin
          cmd.data[n[1:0]] = flag_byte; cmd.valid[n[1:0]] = 1'b1; n = n + 3'd1;
          oc = sat(oc + ONE);
        end
      end
    end else begin
      in_frame_next = 1'b1;
      ic = sat(ic + ONE);
      if (ic >= ml) begin
        err = 1'b1;
      end else if (after_escape) begin
        after_escape_next = 1'b0;
        priority if (in_byte == flag_sub_byte) begin
          cmd.data[n[1:0]] = flag_byte; cmd.valid[n[1:0]] = 1'b1; n = n + 3'd1;
          oc = sat(oc + ONE);
        end else if (in_byte == escape_sub_byte) begin
          cmd.data[n[1:0]] = escape_byte; cmd.valid[n[1:0]] = 1'b1; n = n + 3'd1;
          oc = sat(oc + ONE);
        end else begin
          err = 1'b1;
        end
      end else if (in_byte == escape_byte) begin
        after_escape_next = 1'b1;
      end else begin
        cmd.data[n[1:0]] = in_byte; cmd.valid[n[1:0]] = 1'b1; n = n + 3'd1;
        oc = sat(oc + ONE);
      end
      // empty frame end still needs a result to carry the length
      if (!err && in_last && n == 3'd0) begin
        n = n + 3'd1;
      end
    end
    out_count_next = oc[LEN_BITS-1:0];
    in_count_next  = ic[LEN_BITS-1:0];
    if (err) begin
      n = n + 3'd1;
      cmd.done = 1'b1;
      cmd.err  = 1'b1;
      if (!in_last) begin
        discarding_next = 1'b1;
      end
    end else if (in_last && !discarding) begin
      cmd.done   = 1'b1;
      cmd.length = oc[FLEN_BITS-1:0];
    end
    if (in_last) begin
      in_frame_next     = 1'b0;
      after_escape_next = 1'b0;
      discarding_next   = 1'b0;
      out_count_next    = '0;
      in_count_next     = '0;
    end
    cmd.last_idx = n[1:0] - 2'd1;
  end

  assign push.valid = accept && (n != 3'd0);
  assign push.cmd   = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame     <= 1'b0;
      after_escape <= 1'b0;
      discarding   <= 1'b0;
      out_count    <= '0;
      in_count     <= '0;
    end else if (accept) begin
      in_frame     <= in_frame_next;
      after_escape <= after_escape_next;
      discarding   <= discarding_next;
      out_count    <= out_count_next;
      in_count     <= in_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_mode     <= 1'b0;
      flag_byte       <= 8'd126;
      escape_byte     <= 8'd125;
      flag_sub_byte   <= 8'd1;
      escape_sub_byte <= 8'd2;
      max_len         <= 16'd4096;
    end else if (cfg_we) begin
      unique case (bsf_reg_t'(cfg_index))
        REG_DECODE_MODE:     decode_mode     <= cfg_data[0];
        REG_FLAG_BYTE:       flag_byte       <= cfg_data[7:0];
        REG_ESCAPE_BYTE:     escape_byte     <= cfg_data[7:0];
        REG_FLAG_SUB_BYTE:   flag_sub_byte   <= cfg_data[7:0];
        REG_ESCAPE_SUB_BYTE: escape_sub_byte <= cfg_data[7:0];
        REG_MAX_LEN:         max_len         <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hdl/bsf_queue.sv @@
// ----------------------------------------------------------------------------
// bsf_queue
// Short command queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module bsf_queue #(
  parameter int DEPTH = bsf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bsf_pkg::bsf_push_t push,
  output logic               full,
  output bsf_pkg::bsf_head_t head,
  input  logic               pop
);
  import bsf_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  bsf_cmd_t        entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;
  logic            do_push, do_pop;

  assign full       = (count == CNTW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNTW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNTW'(1);
      end
    end
  end

endmodule

@@ hdl/bsf_back.sv @@
// ----------------------------------------------------------------------------
// bsf_back
// Steps through the results of the head command, one result per cycle
// while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module bsf_back (
  input  logic               clk,
  input  logic               rst,
  input  bsf_pkg::bsf_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte,
  output logic               byte_valid,
  output logic               run_last,
  output logic               frame_done,
  output logic               frame_error,
  output logic [15:0]        frame_length
);
  import bsf_pkg::*;

  logic [SLOT_BITS-1:0] idx;
  logic                 load;
  logic                 is_last;

  assign load    = head.valid && (!out_valid || out_ready);
  assign is_last = (idx == head.cmd.last_idx);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? '0 : idx + SLOT_BITS'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= head.cmd.data[idx];
      byte_valid   <= head.cmd.valid[idx];
      run_last     <= is_last;
      frame_done   <= is_last && head.cmd.done;
      frame_error  <= is_last && head.cmd.err;
      frame_length <= is_last ? head.cmd.length : '0;
    end
  end

endmodule

@@ hdl/byte_stuffing_framer.sv @@
// ----------------------------------------------------------------------------
// byte_stuffing_framer
// Escape framer: stuffs or unstuffs byte frames with configurable codes.
// ----------------------------------------------------------------------------
// The block emits one result per clock on the output stream while the
// output is not stalled. An input item takes as many output slots as
// results it causes: one for a plain byte, two for an escaped byte in
// encode mode, plus one for the opening flag and one for the closing flag,
// so 1 to 4 results; items that cause no result (discarded bytes, a decode
// escape) are taken without using the output. The output sequencer moves
// one result per cycle while not stalled; a command queue of QUEUE_DEPTH
// entries lets input be taken while results still wait. Results pass
// through the command queue and the output register. There is no clearing pass after reset.
module byte_stuffing_framer #(
  parameter int LEN_BITS    = bsf_pkg::LEN_BITS_DEF,
  parameter int QUEUE_DEPTH = bsf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bsf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bsf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // in_byte
  input  logic                              s_axis_tlast,  // frame_last
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [23:0]                       m_axis_tdata,  // out_byte, frame_length
  output logic [2:0]                        m_axis_tuser,  // byte_valid, run_last, frame_error
  output logic                              m_axis_tlast   // frame_done
);
  import bsf_pkg::*;

  bsf_push_t   push;
  bsf_head_t   head;
  logic        q_full;
  logic        pop;
  logic [7:0]  out_byte;
  logic        byte_valid, run_last, frame_done, frame_error;
  logic [15:0] frame_length;

  bsf_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_last   (s_axis_tlast),
    .q_full    (q_full),
    .push      (push)
  );

  bsf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  bsf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .run_last     (run_last),
    .frame_done   (frame_done),
    .frame_error  (frame_error),
    .frame_length (frame_length)
  );

  assign m_axis_tdata = {frame_length, out_byte};
  assign m_axis_tuser = {frame_error, run_last, byte_valid};
  assign m_axis_tlast = frame_done;

endmodule

@@ hdl/bsf_checker.sv @@
// ----------------------------------------------------------------------------
// bsf_checker
// Port-level checks of the framer's result stream.
// ----------------------------------------------------------------------------
module bsf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_we,
  input logic [bsf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input logic [bsf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [7:0]                        s_axis_tdata,
  input logic                              s_axis_tlast,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [23:0]                       m_axis_tdata,
  input logic [2:0]                        m_axis_tuser,
  input logic                              m_axis_tlast
);

  // output register comes up empty
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // frame end closes the run of its item
  a_done_run_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])
    else $error("frame done without run last");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tlast && !m_axis_tuser[0] && m_axis_tdata == 24'd0)
    else $error("malformed error result");

  a_length_on_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[23:8] == 16'd0)
    else $error("frame length outside frame end");

endmodule

bind byte_stuffing_framer bsf_checker u_bsf_checker (.*);

@@ sim/byte_stuffing_framer_tb.sv @@
// ----------------------------------------------------------------------------
// byte_stuffing_framer_tb
// Self-checking bench for the escape framer. Every byte item taken on the
// input stream is run through a predictor of the stuffing and unstuffing
// rules, and each result on the output stream is compared field by field
// with the oldest predicted result. Codes, mode and length limit change
// between phases; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module byte_stuffing_framer_tb;
  import bsf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_CYCLES = 12;
  localparam int REPORT_LINES = 40;

  typedef struct packed {
    logic [15:0] frame_length;
    logic        frame_error;
    logic        frame_done;
    logic        run_last;
    logic        byte_valid;
    logic [7:0]  out_byte;
  } framer_result_t;

  class framer_scoreboard;
    bit             decode_mode;
    logic [7:0]     flag_byte, escape_byte, flag_sub, escape_sub;
    int             max_len;
    bit             in_frame, after_escape, discarding;
    int             out_count, in_count;
    framer_result_t run_results[MAX_RESULTS];
    int             run_count;
    framer_result_t pending_results[$];
    int             errors;

    function new();
      decode_mode = 1'b0;
      flag_byte   = 8'd126;
      escape_byte = 8'd125;
      flag_sub    = 8'd1;
      escape_sub  = 8'd2;
      max_len     = 4096;
      errors      = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      in_frame     = 1'b0;
      after_escape = 1'b0;
      discarding   = 1'b0;
      out_count    = 0;
      in_count     = 0;
    endfunction

    function int sat_inc(int c);
      return (c >= 65535) ? 65535 : c + 1;
    endfunction

    function void write_reg(bsf_reg_t idx, logic [15:0] v);
      case (idx)
        REG_DECODE_MODE:     decode_mode = v[0];
        REG_FLAG_BYTE:       flag_byte   = v[7:0];
        REG_ESCAPE_BYTE:     escape_byte = v[7:0];
        REG_FLAG_SUB_BYTE:   flag_sub    = v[7:0];
        REG_ESCAPE_SUB_BYTE: escape_sub  = v[7:0];
        REG_MAX_LEN:         max_len     = v;
        default: ;
      endcase
    endfunction

    // valid bytes count toward the frame length, markers do not
    function void emit(logic [7:0] b, bit v);
      framer_result_t r;
      r = '0;
      r.out_byte   = v ? b : 8'h00;
      r.byte_valid = v;
      run_results[run_count] = r;
      run_count++;
      if (v) out_count = sat_inc(out_count);
    endfunction

    function void take_byte(logic [7:0] b, logic lst);
      bit err;
      err = 1'b0;
      run_count = 0;
      if (discarding) begin
        if (lst) clear_frame();
        return;
      end
      if (!decode_mode) begin
        if (!in_frame) begin
          emit(flag_byte, 1'b1);
          in_frame = 1'b1;
        end
        // flag match wins when flag and escape codes are equal
        if (b == flag_byte || b == escape_byte) begin
          if (out_count + 2 > max_len) begin
            err = 1'b1;
          end else begin
            emit(escape_byte, 1'b1);
            emit((b == flag_byte) ? flag_sub : escape_sub, 1'b1);
          end
        end else if (out_count + 1 > max_len) begin
          err = 1'b1;
        end else begin
          emit(b, 1'b1);
        end
        if (!err && lst) begin
          if (out_count + 1 > max_len) err = 1'b1;
          else emit(flag_byte, 1'b1);
        end
      end else begin
        in_frame = 1'b1;
        in_count = sat_inc(in_count);
        if (in_count >= max_len) begin
          err = 1'b1;
        end else if (after_escape) begin
          after_escape = 1'b0;
          if (b == flag_sub) emit(flag_byte, 1'b1);
          else if (b == escape_sub) emit(escape_byte, 1'b1);
          else err = 1'b1;
        end else if (b == escape_byte) begin
          after_escape = 1'b1;
        end else begin
          emit(b, 1'b1);
        end
        // frame ending on a dropped lone escape still needs a done marker
        if (!err && lst && run_count == 0) emit(8'h00, 1'b0);
      end
      if (err) begin
        emit(8'h00, 1'b0);
        run_results[run_count-1].frame_done  = 1'b1;
        run_results[run_count-1].frame_error = 1'b1;
        if (lst) clear_frame();
        else discarding = 1'b1;
      end else if (lst) begin
        run_results[run_count-1].frame_done   = 1'b1;
        run_results[run_count-1].frame_length = out_count[15:0];
        clear_frame();
      end
      if (run_count > 0) run_results[run_count-1].run_last = 1'b1;
      for (int k = 0; k < run_count; k++) pending_results.push_back(run_results[k]);
    endfunction

    task report(string msg);
      if (errors < REPORT_LINES) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_output(framer_result_t got);
      framer_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing expected: byte %h valid %b",
                         got.out_byte, got.byte_valid));
        return;
      end
      want = pending_results.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.run_last !== want.run_last || got.frame_done !== want.frame_done ||
          got.frame_error !== want.frame_error ||
          got.frame_length !== want.frame_length)
        report($sformatf("got %h v%b rl%b fd%b fe%b len %0d, want %h v%b rl%b fd%b fe%b len %0d",
                         got.out_byte, got.byte_valid, got.run_last, got.frame_done,
                         got.frame_error, got.frame_length, want.out_byte,
                         want.byte_valid, want.run_last, want.frame_done,
                         want.frame_error, want.frame_length));
    endtask

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [7:0]               s_axis_tdata;   // in_byte
  logic                     s_axis_tlast;   // frame_last
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [23:0]              m_axis_tdata;   // out_byte, frame_length
  logic [2:0]               m_axis_tuser;   // byte_valid, run_last, frame_error
  logic                     m_axis_tlast;   // frame_done

  framer_scoreboard sb;
  bit               tx_gaps;
  bit               rx_stalls;
  int               cycles = 0;

  byte_stuffing_framer dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("byte_stuffing_framer verification failed");
      $finish;
    end
  end

  // watch both streams and the register port
  always @(posedge clk) begin
    framer_result_t got;
    if (!rst) begin
      if (cfg_we) sb.write_reg(bsf_reg_t'(cfg_index), cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.take_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_byte     = m_axis_tdata[7:0];
        got.frame_length = m_axis_tdata[23:8];
        got.byte_valid   = m_axis_tuser[0];
        got.run_last     = m_axis_tuser[1];
        got.frame_error  = m_axis_tuser[2];
        got.frame_done   = m_axis_tlast;
        sb.check_output(got);
      end
    end
  end

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 20);
  endfunction

  initial begin
    int n;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_stalls && $urandom_range(0, 3) == 0) begin
        n = pause_len();
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task send_byte(logic [7:0] b, logic lst);
    int gap;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    gap = (tx_gaps && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task put_reg(bsf_reg_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task set_config(bit dm, logic [7:0] fl, logic [7:0] es, logic [7:0] fs,
                  logic [7:0] ss, logic [15:0] ml);
    drain_results();
    // a discarded item may still be in flight with nothing expected
    repeat (IDLE_CYCLES) @(posedge clk);
    put_reg(REG_DECODE_MODE, {15'd0, dm});
    put_reg(REG_FLAG_BYTE, {8'd0, fl});
    put_reg(REG_ESCAPE_BYTE, {8'd0, es});
    put_reg(REG_FLAG_SUB_BYTE, {8'd0, fs});
    put_reg(REG_ESCAPE_SUB_BYTE, {8'd0, ss});
    put_reg(REG_MAX_LEN, ml);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return sb.flag_byte;
    if (r < 4) return sb.escape_byte;
    return 8'($urandom_range(0, 255));
  endfunction

  // encode: random payload; decode: mostly well-formed stuffed data,
  // sometimes a bad escape, a trailing lone escape or raw noise
  task automatic send_frame(output int count);
    logic [7:0] bytes[$];
    logic [7:0] b, bad;
    int         n, kind, pos, k;
    n    = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
    kind = $urandom_range(0, 9);
    for (k = 0; k < n; k++) begin
      b = pick_byte();
      if (!sb.decode_mode || kind == 9) begin
        bytes.push_back(b);
      end else if (b == sb.escape_byte) begin
        bytes.push_back(sb.escape_byte);
        bytes.push_back(sb.escape_sub);
      end else if (b == sb.flag_byte && $urandom_range(0, 1) == 1) begin
        bytes.push_back(sb.escape_byte);
        bytes.push_back(sb.flag_sub);
      end else begin
        bytes.push_back(b);
      end
    end
    if (sb.decode_mode && kind == 7) begin
      do bad = 8'($urandom_range(0, 255)); while (bad == sb.flag_sub || bad == sb.escape_sub);
      pos = $urandom_range(0, bytes.size());
      bytes.insert(pos, bad);
      bytes.insert(pos, sb.escape_byte);
    end
    if (sb.decode_mode && kind == 8) bytes.push_back(sb.escape_byte);
    for (k = 0; k < bytes.size(); k++) begin
      send_byte(bytes[k], k == bytes.size() - 1);
      if (k == bytes.size() / 2 && $urandom_range(0, 19) == 0) drain_results();
    end
    count = bytes.size();
  endtask

  initial begin
    int         sent, cnt;
    bit         dm;
    logic [7:0] fl, es, fs, ss;
    logic [15:0] ml;
    sb = new();
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_DECODE_MODE;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // encode with reset codes: byte extremes, flag and escape in data
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h7D, 1'b0);
    send_byte(8'hFF, 1'b1);
    // one-byte frames that need escaping: four results from one item
    send_byte(8'h7E, 1'b1);
    drain_results();
    send_byte(8'h7D, 1'b1);

    // decode: escapes undone, flag passes through
    set_config(1'b1, 8'h7E, 8'h7D, 8'h01, 8'h02, 16'd4096);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h7D, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7D, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'hFF, 1'b1);
    // bad escape, rest of frame discarded
    send_byte(8'h7D, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    // trailing lone escape dropped
    send_byte(8'h41, 1'b0);
    send_byte(8'h7D, 1'b1);

    // encode at a limit of two: closing flag and escape both overflow
    set_config(1'b0, 8'h00, 8'hFF, 8'hFF, 8'h00, 16'd2);
    send_byte(8'h10, 1'b1);
    send_byte(8'h00, 1'b1);

    // equal flag and escape codes in encode
    set_config(1'b0, 8'h55, 8'h55, 8'hAA, 8'hBB, 16'hFFFF);
    send_byte(8'h55, 1'b1);

    // equal substitutes in decode, then length overflow
    set_config(1'b1, 8'hFF, 8'h00, 8'h80, 8'h80, 16'd3);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      dm = ph[0];
      fl = 8'($urandom_range(0, 255));
      es = ($urandom_range(0, 5) == 0) ? fl : 8'($urandom_range(0, 255));
      fs = 8'($urandom_range(0, 255));
      ss = ($urandom_range(0, 5) == 0) ? fs : 8'($urandom_range(0, 255));
      if (ph == 1) begin
        fl = 8'hFF;
        es = 8'h00;
      end
      case ($urandom_range(0, 3))
        0:       ml = 16'hFFFF;
        1:       ml = 16'($urandom_range(2, 8));
        default: ml = 16'($urandom_range(9, 30));
      endcase
      if (ph == 0) ml = 16'hFFFF;
      set_config(dm, fl, es, fs, ss, ml);
      tx_gaps   = (ph != 0) && ($urandom_range(0, 3) != 0);
      rx_stalls = (ph != 0) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < 21) begin
        send_frame(cnt);
        sent += cnt;
      end
    end

    drain_results();
    repeat (IDLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("byte_stuffing_framer verification clean");
    end else begin
      $display("byte_stuffing_framer verification failed");
    end
    $finish;
  end

endmodule
